@@ src/nec_ir_frame_transmitter_assert.svh @@
// Assertion macros shared by the transmitter RTL
`ifndef NEC_IR_FRAME_TRANSMITTER_ASSERT_SVH
`define NEC_IR_FRAME_TRANSMITTER_ASSERT_SVH

// same-cycle implication
`define NIRTX_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nirtx check failed");

// next-cycle implication
`define NIRTX_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nirtx check failed");

`endif

@@ src/nirtx_pkg.sv @@
// Types and constants of the NEC IR frame transmitter
`timescale 1ns / 1ps
package nirtx_pkg;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_HDR_BURST = 3'd1,
      PH_HDR_SPACE = 3'd2,
      PH_BIT_SPACE = 3'd3,
      PH_BIT_BURST = 3'd4,
      PH_GAP       = 3'd5
   } phase_type;

   typedef struct packed {
      logic       command;
      logic [7:0] payload;
   } req_type;

   typedef struct packed {
      logic ir_level;
      logic busy_res;
      logic frame_done;
      logic start_ignored;
   } rsp_type;

   typedef struct packed {
      logic [15:0] carrier_low_ticks;
      logic [15:0] carrier_high_ticks;
      logic [15:0] space_period_ticks;
      logic [15:0] address_code;
      logic [15:0] millisecond_ticks;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [31:0] frame_bits;
   } entry_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } qstat_type;

   // register indexes
   localparam logic [2:0] CSR_CARRIER_LOW  = 3'd0;
   localparam logic [2:0] CSR_CARRIER_HIGH = 3'd1;
   localparam logic [2:0] CSR_SPACE_PERIOD = 3'd2;
   localparam logic [2:0] CSR_ADDRESS      = 3'd3;
   localparam logic [2:0] CSR_MILLISECOND  = 3'd4;

   localparam logic [15:0] CARRIER_LOW_RESET  = 16'd99;
   localparam logic [15:0] CARRIER_HIGH_RESET = 16'd190;
   localparam logic [15:0] SPACE_PERIOD_RESET = 16'd290;
   localparam logic [15:0] ADDRESS_RESET      = 16'hFF00;
   localparam logic [15:0] MILLISECOND_RESET  = 16'd11059;

   localparam logic [8:0] HDR_BURST_CYCLES  = 9'd342;
   localparam logic [8:0] HDR_SPACE_PERIODS = 9'd171;
   localparam logic [8:0] BIT_BURST_CYCLES  = 9'd21;
   localparam logic [8:0] ONE_SPACE_PERIODS = 9'd63;
   localparam logic [8:0] ZERO_SPACE_PERIODS = 9'd21;
   localparam logic [6:0] FRAME_UNITS       = 7'd56;

endpackage

@@ src/nirtx_front.sv @@
// Front end: accepts transactions and builds the frame word for a start
`timescale 1ns / 1ps
module nirtx_front import nirtx_pkg::*; (
   input  logic      req_valid,
   input  req_type   req_data,
   input  logic      queue_full,
   input  logic [15:0] address_code,
   output logic      push,
   output entry_type entry
);

   assign push = req_valid && !queue_full;

   // address low, address high, data, inverted data; sent LSB first
   always_comb begin
      entry.start      = req_data.command;
      entry.frame_bits = {~req_data.payload, req_data.payload, address_code};
   end

endmodule

@@ src/nirtx_queue.sv @@
// Short queue between the front end and the waveform engine
`timescale 1ns / 1ps
module nirtx_queue import nirtx_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output qstat_type status
);

   entry_type         slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) r = '0;
      else r = p + QPTR_W'(1);
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      else if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_entry;
   end

   assign head         = slots_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

endmodule

@@ src/nirtx_engine.sv @@
// Waveform engine: segment sequencer, tick counter and result register
`timescale 1ns / 1ps
module nirtx_engine import nirtx_pkg::*; #(
   parameter int TICK_COUNTER_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  entry_type head,
   input  logic      head_valid,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   localparam int TW = TICK_COUNTER_WIDTH;
   localparam int CW = (TW > 16) ? TW : 16;
   localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};

   phase_type   phase_ff, phase_in;
   logic [31:0] frame_ff, frame_in;
   logic [5:0]  bitpos_ff, bitpos_in;
   logic [8:0]  periods_ff, periods_in;
   logic [TW-1:0] tick_ff, tick_in;
   logic        pin_ff, pin_in;
   logic [6:0]  units_ff, units_in;
   logic [4:0]  gap_ff, gap_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic          out_ready;
   logic          start;
   logic [TW-1:0] cnt_inc;
   logic [15:0]   limit;
   logic          hit;
   logic [8:0]    per_dec;
   logic          per_zero;
   logic [4:0]    gap_dec;
   logic          cur_bit;
   logic          bits_left;
   logic [6:0]    gap_d;
   logic [4:0]    gap_calc;
   logic          done;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign pop       = head_valid && out_ready;
   assign start     = head.start;

   // saturating tick counter and phase limit
   assign cnt_inc = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + TW'(1);

   always_comb begin
      case (phase_ff)
         PH_HDR_BURST, PH_BIT_BURST:
            limit = pin_ff ? cfg.carrier_high_ticks : cfg.carrier_low_ticks;
         PH_HDR_SPACE, PH_BIT_SPACE: limit = cfg.space_period_ticks;
         PH_GAP:                     limit = cfg.millisecond_ticks;
         default:                    limit = cfg.millisecond_ticks;
      endcase
   end

   assign hit       = (CW'(cnt_inc) >= CW'(limit)) || (cnt_inc == TICK_MAX);
   assign per_dec   = periods_ff - 9'd1;
   assign per_zero  = (per_dec == '0);
   assign gap_dec   = gap_ff - 5'd1;
   assign cur_bit   = frame_ff[bitpos_ff[4:0]];
   assign bits_left = !bitpos_ff[5];
   // gap of d + d/8 ms where d = 56 - bit units
   assign gap_d     = FRAME_UNITS - units_ff;
   assign gap_calc  = (units_ff < FRAME_UNITS) ? 5'(gap_d + (gap_d >> 3)) : 5'd0;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (start) phase_in = PH_HDR_BURST;
         end
         PH_HDR_BURST: begin
            if (pin_ff && hit && per_zero) phase_in = PH_HDR_SPACE;
         end
         PH_BIT_BURST: begin
            if (pin_ff && hit && per_zero) begin
               if (bits_left) phase_in = PH_BIT_SPACE;
               else if (gap_calc != '0) phase_in = PH_GAP;
               else phase_in = PH_IDLE;
            end
         end
         PH_HDR_SPACE, PH_BIT_SPACE: begin
            if (hit && per_zero) phase_in = PH_BIT_BURST;
         end
         PH_GAP: begin
            if (hit && (gap_dec == '0)) phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      frame_in   = frame_ff;
      bitpos_in  = bitpos_ff;
      periods_in = periods_ff;
      tick_in    = tick_ff;
      pin_in     = pin_ff;
      units_in   = units_ff;
      gap_in     = gap_ff;
      done       = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               frame_in   = head.frame_bits;
               bitpos_in  = '0;
               units_in   = '0;
               gap_in     = '0;
               periods_in = HDR_BURST_CYCLES;
               tick_in    = '0;
               pin_in     = 1'b0;
            end
         end
         PH_HDR_BURST, PH_BIT_BURST: begin
            tick_in = cnt_inc;
            if (!pin_ff) begin
               if (hit) begin
                  pin_in  = 1'b1;
                  tick_in = '0;
               end
            end else if (hit) begin
               tick_in    = '0;
               periods_in = per_dec;
               if (!per_zero) begin
                  pin_in = 1'b0;
               end else if (phase_ff == PH_HDR_BURST) begin
                  periods_in = HDR_SPACE_PERIODS;
                  pin_in     = 1'b1;
               end else if (bits_left) begin
                  units_in   = units_ff + (cur_bit ? 7'd2 : 7'd1);
                  bitpos_in  = bitpos_ff + 6'd1;
                  periods_in = cur_bit ? ONE_SPACE_PERIODS : ZERO_SPACE_PERIODS;
                  pin_in     = 1'b1;
               end else begin
                  pin_in     = 1'b1;
                  periods_in = '0;
                  gap_in     = gap_calc;
                  done       = (gap_calc == '0);
               end
            end
         end
         PH_HDR_SPACE, PH_BIT_SPACE: begin
            tick_in = cnt_inc;
            if (hit) begin
               tick_in    = '0;
               periods_in = per_dec;
               if (per_zero) begin
                  periods_in = BIT_BURST_CYCLES;
                  pin_in     = 1'b0;
               end
            end
         end
         PH_GAP: begin
            tick_in = cnt_inc;
            if (hit) begin
               tick_in = '0;
               gap_in  = gap_dec;
               done    = (gap_dec == '0);
            end
         end
         default: pin_in = 1'b1;
      endcase
      rsp_data_in.ir_level      = pin_in;
      rsp_data_in.busy_res      = (phase_in != PH_IDLE);
      rsp_data_in.frame_done    = done;
      rsp_data_in.start_ignored = start && (phase_ff != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         frame_ff     <= '0;
         bitpos_ff    <= '0;
         periods_ff   <= '0;
         tick_ff      <= '0;
         pin_ff       <= 1'b1;
         units_ff     <= '0;
         gap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff   <= phase_in;
            frame_ff   <= frame_in;
            bitpos_ff  <= bitpos_in;
            periods_ff <= periods_in;
            tick_ff    <= tick_in;
            pin_ff     <= pin_in;
            units_ff   <= units_in;
            gap_ff     <= gap_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/nec_ir_frame_transmitter.sv @@
// Top level of the NEC IR frame transmitter
//
//   port group   dir   carries
//   req_*        in    one timebase tick: command, payload
//   rsp_*        out   pin level, busy, frame done, start ignored
//   csr_*        in    register writes, index 0..4, 16-bit data
//
// One transaction per cycle sustained while rsp_stall is low; a request passes
// through the two-entry queue and then the result register.
// Reset is synchronous and leaves the pin idle high with the reset timings.
// A stalled result holds the engine; the queue keeps taking requests until
// it is full, then req_stall rises.
`timescale 1ns / 1ps
`include "nec_ir_frame_transmitter_assert.svh"
module nec_ir_frame_transmitter import nirtx_pkg::*; #(
   parameter int TICK_COUNTER_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   cfg_type   cfg_ff, cfg_in;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type head;
   qstat_type qstat;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CARRIER_LOW:  cfg_in.carrier_low_ticks  = csr_write_data;
            CSR_CARRIER_HIGH: cfg_in.carrier_high_ticks = csr_write_data;
            CSR_SPACE_PERIOD: cfg_in.space_period_ticks = csr_write_data;
            CSR_ADDRESS:      cfg_in.address_code       = csr_write_data;
            CSR_MILLISECOND:  cfg_in.millisecond_ticks  = csr_write_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.carrier_low_ticks  <= CARRIER_LOW_RESET;
         cfg_ff.carrier_high_ticks <= CARRIER_HIGH_RESET;
         cfg_ff.space_period_ticks <= SPACE_PERIOD_RESET;
         cfg_ff.address_code       <= ADDRESS_RESET;
         cfg_ff.millisecond_ticks  <= MILLISECOND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = qstat.full;

   nirtx_front u_front (
      .req_valid    (req_valid),
      .req_data     (req_data),
      .queue_full   (qstat.full),
      .address_code (cfg_ff.address_code),
      .push         (push),
      .entry        (push_entry)
   );

   nirtx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (qstat)
   );

   nirtx_engine #(
      .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .head_valid (!qstat.empty),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   `NIRTX_ASSERT_NOW(a_no_push_when_full, clock, reset, qstat.full, !push)
   `NIRTX_ASSERT_NOW(a_pop_only_with_room, clock, reset, pop, (!qstat.empty) && (!rsp_valid || !rsp_stall))
   `NIRTX_ASSERT_NOW(a_done_means_idle, clock, reset, rsp_valid && rsp_data.frame_done, !rsp_data.busy_res)
   `NIRTX_ASSERT_NEXT(a_pop_gives_result, clock, reset, pop, rsp_valid)

endmodule
